// ===== rtl/sqb_pkg.sv =====
// ============================================================================
// sqb_pkg
// Shared types, constants and helpers of the sprite quad batcher.
// ============================================================================
`default_nettype none

package sqb_pkg;

    localparam int SLOT_COUNT_DEF = 16;
    localparam int BATCH_MAX_DEF  = 1024;

    localparam logic [10:0] BATCH_LIMIT_RST = 11'd1000;
    localparam logic [15:0] CLIP_SCALE_RST  = 16'd655;

    localparam logic REG_BATCH_LIMIT = 1'b0;
    localparam logic REG_CLIP_SCALE  = 1'b1;

    localparam logic [1:0] OP_SUBMIT = 2'd0;
    localparam logic [1:0] OP_BEGIN  = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;

    localparam logic [1:0] KIND_VERTEX = 2'd0;
    localparam logic [1:0] KIND_BIND   = 2'd1;
    localparam logic [1:0] KIND_DRAW   = 2'd2;

    localparam int CORDIC_STEPS = 15;
    localparam logic signed [17:0] CORDIC_X0 = 18'sd19898;

    typedef enum logic [1:0] {
        CMD_SUBMIT,
        CMD_BEGIN,
        CMD_FLUSH
    } cmd_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [15:0] pivot_x;
        logic [15:0] pivot_y;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] angle;
        logic [31:0] color_rgba;
        logic [31:0] texture_handle;
    } sprite_cmd_t;

    function automatic logic [13:0] atan_unit(input logic [3:0] step);
        logic [13:0] val;
        case (step)
            4'd0:    val = 14'd8192;
            4'd1:    val = 14'd4836;
            4'd2:    val = 14'd2555;
            4'd3:    val = 14'd1297;
            4'd4:    val = 14'd651;
            4'd5:    val = 14'd326;
            4'd6:    val = 14'd163;
            4'd7:    val = 14'd81;
            4'd8:    val = 14'd41;
            4'd9:    val = 14'd20;
            4'd10:   val = 14'd10;
            4'd11:   val = 14'd5;
            4'd12:   val = 14'd3;
            4'd13:   val = 14'd1;
            4'd14:   val = 14'd1;
            default: val = 14'd0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sqb_front.sv =====
// ============================================================================
// sqb_front
// Accepts input words, decodes the operation and drops unused codes.
// ============================================================================
`default_nettype none

module sqb_front
    import sqb_pkg::*;
(
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [175:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         q_ready,
    output logic              q_push,
    output sprite_cmd_t       q_data
);

    cmd_t cmd;
    logic known;

    always_comb
    begin
        cmd   = CMD_SUBMIT;
        known = 1'b1;
        case (s_tuser)
            OP_SUBMIT: cmd = CMD_SUBMIT;
            OP_BEGIN:  cmd = CMD_BEGIN;
            OP_FLUSH:  cmd = CMD_FLUSH;
            default:   known = 1'b0;
        endcase
    end

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready && known;

    always_comb
    begin
        q_data.cmd            = cmd;
        q_data.pos_x          = s_tdata[15:0];
        q_data.pos_y          = s_tdata[31:16];
        q_data.pivot_x        = s_tdata[47:32];
        q_data.pivot_y        = s_tdata[63:48];
        q_data.width          = s_tdata[79:64];
        q_data.height         = s_tdata[95:80];
        q_data.angle          = s_tdata[111:96];
        q_data.color_rgba     = s_tdata[143:112];
        q_data.texture_handle = s_tdata[175:144];
    end

endmodule

`default_nettype wire

// ===== rtl/sqb_fifo.sv =====
// ============================================================================
// sqb_fifo
// Two-entry command queue between the front and back ends.
// ============================================================================
`default_nettype none

module sqb_fifo
    import sqb_pkg::*;
#(
    parameter int WIDTH = 8
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  push_ready,
    input  wire logic             pop,
    output logic                  pop_valid,
    output logic [WIDTH-1:0]      pop_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sqb_back.sv =====
// ============================================================================
// sqb_back
// Executes commands: slot table, flush records, CORDIC and corner math.
// ============================================================================
`default_nettype none

module sqb_back
    import sqb_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int BATCH_MAX  = BATCH_MAX_DEF
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cfg_we,
    input  wire logic          cfg_addr,
    input  wire logic [15:0]   cfg_wdata,
    input  wire logic          q_valid,
    input  wire sprite_cmd_t   q_data,
    output logic               q_pop,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [119:0]       m_tdata,
    output logic [1:0]         m_tuser,
    output logic               m_tlast
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(SLOT_COUNT + 1);
    localparam int PW = $clog2(BATCH_MAX + 1);
    localparam logic [CW-1:0] SLOT_FULL = CW'(SLOT_COUNT);
    localparam logic [15:0]   LIMIT_MAX = 16'(BATCH_MAX);

    typedef enum logic [3:0] {
        ST_IDLE, ST_BIND, ST_DRAW, ST_SEARCH, ST_ALLOC, ST_CORDIC,
        ST_QUAD, ST_MUL0, ST_MUL1, ST_MUL2, ST_MUL3, ST_MUL4, ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        RET_IDLE, RET_SEARCH, RET_ALLOC
    } ret_t;

    state_t        state_reg;
    ret_t          ret_reg;
    logic          flush_last_reg;
    logic [10:0]   batch_limit_reg;
    logic [15:0]   clip_scale_reg;
    logic [CW-1:0] slots_used_reg;
    logic [PW-1:0] pending_reg;
    logic [CW-1:0] idx_reg;
    logic [SW-1:0] slot_reg;
    sprite_cmd_t   item_reg;
    logic [31:0]   table_reg [SLOT_COUNT];

    logic signed [17:0] cx_reg, cy_reg, cz_reg, cos_reg, sin_reg;
    logic [3:0]         step_reg;
    logic [1:0]         quad_reg;
    logic [1:0]         corner_reg;
    logic [31:0]        pwx_reg, pwy_reg;
    logic signed [33:0] ox_reg, oy_reg;
    logic signed [51:0] cox_reg, soy_reg, sox_reg, coy_reg;
    logic signed [23:0] wx_reg, wy_reg;
    logic signed [40:0] vx_reg, vy_reg;

    logic          out_valid_reg;
    logic [1:0]    out_kind_reg;
    logic [114:0]  out_data_reg;
    logic          out_last_reg;

    logic          can_emit;
    logic          emit_now;
    logic [31:0]   table_rd;
    logic [15:0]   limit;
    logic [15:0]   pend16;
    logic [12:0]   draw_count;
    logic [1:0]    quad;
    logic [15:0]   zinit;
    logic signed [17:0] xs, ys;
    logic signed [17:0] atan_s;
    logic signed [52:0] rx, ry;
    logic signed [22:0] rox, roy;
    logic signed [40:0] vxr, vyr;
    logic signed [15:0] clip_x, clip_y;

    assign can_emit  = !out_valid_reg || m_tready;
    assign emit_now  = can_emit && (((state_reg == ST_BIND) && (idx_reg < slots_used_reg))
                                    || (state_reg == ST_DRAW) || (state_reg == ST_EMIT));
    assign table_rd  = table_reg[idx_reg[SW-1:0]];
    assign limit     = (16'(batch_limit_reg) > LIMIT_MAX) ? LIMIT_MAX : 16'(batch_limit_reg);
    assign pend16    = 16'(pending_reg);
    assign draw_count = 13'((pend16 << 2) + (pend16 << 1));
    assign quad      = 2'((q_data.angle + 16'd8192) >> 14);
    assign zinit     = item_reg.angle - {quad_reg, 14'd0};
    assign xs        = cx_reg >>> step_reg;
    assign ys        = cy_reg >>> step_reg;
    assign atan_s    = $signed({4'd0, atan_unit(step_reg)});
    assign rx        = 53'(cox_reg) - 53'(soy_reg);
    assign ry        = 53'(sox_reg) + 53'(coy_reg);
    assign rox       = 23'((rx + 53'sd536870912) >>> 30);
    assign roy       = 23'((ry + 53'sd536870912) >>> 30);
    assign vxr       = (vx_reg + 41'sd128) >>> 8;
    assign vyr       = (vy_reg + 41'sd128) >>> 8;
    assign clip_x    = (vxr > 41'sd32767) ? 16'sh7fff :
                       (vxr < -41'sd32768) ? 16'sh8000 : vxr[15:0];
    assign clip_y    = (vyr > 41'sd32767) ? 16'sh7fff :
                       (vyr < -41'sd32768) ? 16'sh8000 : vyr[15:0];
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {5'd0, out_data_reg};
    assign m_tlast  = out_last_reg;

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_ALLOC)
        begin
            if (slots_used_reg >= SLOT_FULL)
            begin
                table_reg[0] <= item_reg.texture_handle;
            end
            else
            begin
                table_reg[slots_used_reg[SW-1:0]] <= item_reg.texture_handle;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            ret_reg         <= RET_IDLE;
            flush_last_reg  <= 1'b0;
            batch_limit_reg <= BATCH_LIMIT_RST;
            clip_scale_reg  <= CLIP_SCALE_RST;
            slots_used_reg  <= '0;
            pending_reg     <= '0;
            idx_reg         <= '0;
            out_valid_reg   <= 1'b0;
            out_kind_reg    <= KIND_VERTEX;
            out_data_reg    <= '0;
            out_last_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_addr == REG_BATCH_LIMIT)
                begin
                    batch_limit_reg <= cfg_wdata[10:0];
                end
                else
                begin
                    clip_scale_reg <= cfg_wdata;
                end
            end
            if (emit_now)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    idx_reg <= '0;
                    if (q_valid)
                    begin
                        item_reg <= q_data;
                        quad_reg <= quad;
                        case (q_data.cmd)
                            CMD_BEGIN:
                            begin
                                slots_used_reg <= '0;
                                pending_reg    <= '0;
                            end
                            CMD_FLUSH:
                            begin
                                flush_last_reg <= 1'b1;
                                ret_reg        <= RET_IDLE;
                                if (pending_reg != '0)
                                begin
                                    state_reg <= ST_BIND;
                                end
                            end
                            default:
                            begin
                                flush_last_reg <= 1'b0;
                                ret_reg        <= RET_SEARCH;
                                if (pend16 >= limit && pending_reg != '0)
                                begin
                                    state_reg <= ST_BIND;
                                end
                                else
                                begin
                                    state_reg <= ST_SEARCH;
                                end
                            end
                        endcase
                    end
                end
                ST_BIND:
                begin
                    if (idx_reg >= slots_used_reg)
                    begin
                        state_reg <= ST_DRAW;
                    end
                    else if (can_emit)
                    begin
                        out_kind_reg  <= KIND_BIND;
                        out_last_reg  <= 1'b0;
                        out_data_reg  <= {13'd0, table_rd, 4'(idx_reg), 32'd0, 2'd0, 32'd0};
                        idx_reg       <= idx_reg + CW'(1);
                    end
                end
                ST_DRAW:
                begin
                    if (can_emit)
                    begin
                        out_kind_reg  <= KIND_DRAW;
                        out_last_reg  <= flush_last_reg;
                        out_data_reg  <= {draw_count, 102'd0};
                        pending_reg   <= '0;
                        idx_reg       <= '0;
                        case (ret_reg)
                            RET_SEARCH: state_reg <= ST_SEARCH;
                            RET_ALLOC:  state_reg <= ST_ALLOC;
                            default:    state_reg <= ST_IDLE;
                        endcase
                    end
                end
                ST_SEARCH:
                begin
                    if (idx_reg >= slots_used_reg)
                    begin
                        if (slots_used_reg >= SLOT_FULL && pending_reg != '0)
                        begin
                            ret_reg   <= RET_ALLOC;
                            idx_reg   <= '0;
                            state_reg <= ST_BIND;
                        end
                        else
                        begin
                            state_reg <= ST_ALLOC;
                        end
                    end
                    else if (table_rd == item_reg.texture_handle)
                    begin
                        slot_reg  <= idx_reg[SW-1:0];
                        state_reg <= ST_CORDIC;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + CW'(1);
                    end
                    cx_reg   <= CORDIC_X0;
                    cy_reg   <= '0;
                    cz_reg   <= 18'($signed(zinit));
                    step_reg <= '0;
                end
                ST_ALLOC:
                begin
                    if (slots_used_reg >= SLOT_FULL)
                    begin
                        slot_reg       <= '0;
                        slots_used_reg <= CW'(1);
                    end
                    else
                    begin
                        slot_reg       <= slots_used_reg[SW-1:0];
                        slots_used_reg <= slots_used_reg + CW'(1);
                    end
                    state_reg <= ST_CORDIC;
                end
                ST_CORDIC:
                begin
                    if (cz_reg >= 0)
                    begin
                        cx_reg <= cx_reg - ys;
                        cy_reg <= cy_reg + xs;
                        cz_reg <= cz_reg - atan_s;
                    end
                    else
                    begin
                        cx_reg <= cx_reg + ys;
                        cy_reg <= cy_reg - xs;
                        cz_reg <= cz_reg + atan_s;
                    end
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= ST_QUAD;
                    end
                end
                ST_QUAD:
                begin
                    case (quad_reg)
                        2'd0:
                        begin
                            cos_reg <= cx_reg;
                            sin_reg <= cy_reg;
                        end
                        2'd1:
                        begin
                            cos_reg <= -cy_reg;
                            sin_reg <= cx_reg;
                        end
                        2'd2:
                        begin
                            cos_reg <= -cx_reg;
                            sin_reg <= -cy_reg;
                        end
                        default:
                        begin
                            cos_reg <= cy_reg;
                            sin_reg <= -cx_reg;
                        end
                    endcase
                    corner_reg <= 2'd0;
                    state_reg  <= ST_MUL0;
                end
                ST_MUL0:
                begin
                    pwx_reg   <= item_reg.pivot_x * item_reg.width;
                    pwy_reg   <= item_reg.pivot_y * item_reg.height;
                    state_reg <= ST_MUL1;
                end
                ST_MUL1:
                begin
                    ox_reg <= (corner_reg[0] ? $signed({3'd0, item_reg.width, 15'd0}) : 34'sd0)
                              - $signed({2'd0, pwx_reg});
                    oy_reg <= (corner_reg[1] ? $signed({3'd0, item_reg.height, 15'd0}) : 34'sd0)
                              - $signed({2'd0, pwy_reg});
                    state_reg <= ST_MUL2;
                end
                ST_MUL2:
                begin
                    cox_reg   <= cos_reg * ox_reg;
                    soy_reg   <= sin_reg * oy_reg;
                    sox_reg   <= sin_reg * ox_reg;
                    coy_reg   <= cos_reg * oy_reg;
                    state_reg <= ST_MUL3;
                end
                ST_MUL3:
                begin
                    wx_reg    <= 24'($signed(item_reg.pos_x)) + 24'(rox);
                    wy_reg    <= 24'($signed(item_reg.pos_y)) + 24'(roy);
                    state_reg <= ST_MUL4;
                end
                ST_MUL4:
                begin
                    vx_reg    <= wx_reg * $signed({1'b0, clip_scale_reg});
                    vy_reg    <= wy_reg * $signed({1'b0, clip_scale_reg});
                    state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (can_emit)
                    begin
                        out_kind_reg  <= KIND_VERTEX;
                        out_last_reg  <= (corner_reg == 2'd3);
                        out_data_reg  <= {13'd0, 32'd0, 4'(slot_reg), item_reg.color_rgba,
                                          corner_reg, clip_y, clip_x};
                        corner_reg    <= corner_reg + 2'd1;
                        if (corner_reg == 2'd3)
                        begin
                            pending_reg <= pending_reg + PW'(1);
                            state_reg   <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_MUL0;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sprite_quad_batcher_top.sv =====
// ============================================================================
// sprite_quad_batcher_top
// Sprite batcher: streams quad vertices, texture binds and draw records.
// ============================================================================
// A submitted sprite passes through the execution unit in order: the word is
// taken, the texture slot table is checked entry by entry, a slot is allocated
// when the handle is new, the shared CORDIC rotator runs, the quadrant is folded
// in, and each corner goes through a five-stage multiply sequence and the
// output word. A flush emits a bind word per bound slot and then the draw
// record. Output stalls can hold any of these steps. Input words queue in a
// two-word command buffer, so the input side keeps taking words, until that
// buffer is full, while results wait on the output register.
`default_nettype none

module sprite_quad_batcher_top
    import sqb_pkg::*;
#(
    parameter int SLOT_COUNT = SLOT_COUNT_DEF,
    parameter int BATCH_MAX  = BATCH_MAX_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         cfg_we,
    input  wire logic         cfg_addr,
    input  wire logic [15:0]  cfg_wdata,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // pos_x, pos_y, pivot_x, pivot_y, width, height, angle, color_rgba, texture_handle
    input  wire logic [175:0] s_tdata,
    // operation
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // clip_x, clip_y, corner, vertex_color, slot, bound_handle, index_count, zero pad
    output logic [119:0]      m_tdata,
    // kind
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);

    logic        q_ready;
    logic        q_push;
    sprite_cmd_t q_in;
    logic        q_pop;
    logic        q_valid;
    sprite_cmd_t q_out;

    sqb_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_ready  (q_ready),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    sqb_fifo #(
        .WIDTH ($bits(sprite_cmd_t))
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_in),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_data   (q_out)
    );

    sqb_back #(
        .SLOT_COUNT (SLOT_COUNT),
        .BATCH_MAX  (BATCH_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_data    (q_out),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire
